[sv/lwfs_pkg.sv]
// Shared types and constants for the laser wall-follow speed selector.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lwfs_pkg;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned TURN_W  = 10;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [RANGE_W-1:0] MIN_START = 16'd5000;

  localparam logic [SPEED_W-1:0] SPEED_CRAWL  = 8'd10;
  localparam logic [SPEED_W-1:0] SPEED_SLOW   = 8'd50;
  localparam logic [SPEED_W-1:0] SPEED_MEDIUM = 8'd150;
  localparam logic [SPEED_W-1:0] SPEED_FAST   = 8'd250;

  localparam logic signed [TURN_W-1:0] TURN_NONE  = 10'sd0;
  localparam logic signed [TURN_W-1:0] TURN_LEFT  = 10'sd300;
  localparam logic signed [TURN_W-1:0] TURN_RIGHT = -10'sd300;

  localparam logic [LEN_W-1:0]   RST_SCAN_LENGTH      = 13'd640;
  localparam logic [RANGE_W-1:0] RST_STOP_DISTANCE    = 16'd400;
  localparam logic [RANGE_W-1:0] RST_WALL_DISTANCE    = 16'd600;
  localparam logic [RANGE_W-1:0] RST_CAUTION_DISTANCE = 16'd800;
  localparam logic [RANGE_W-1:0] RST_FOLLOW_DISTANCE  = 16'd900;

  typedef enum logic [2:0] {
    REG_SCAN_LENGTH      = 3'd0,
    REG_STOP_DISTANCE    = 3'd1,
    REG_WALL_DISTANCE    = 3'd2,
    REG_CAUTION_DISTANCE = 3'd3,
    REG_FOLLOW_DISTANCE  = 3'd4
  } lwfs_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range;
    logic               left_closer;
    logic [RANGE_W-1:0] first_range;
    logic [RANGE_W-1:0] last_range;
  } lwfs_scan_t;

  typedef struct packed {
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] third;
    logic [LEN_W-1:0] two_third;
  } lwfs_split_t;

  typedef struct packed {
    logic [RANGE_W-1:0] stop_dist;
    logic [RANGE_W-1:0] wall_dist;
    logic [RANGE_W-1:0] caution_dist;
    logic [RANGE_W-1:0] follow_dist;
  } lwfs_thresh_t;

  // Exact floor(x / 3) for x below 3 * 2**13 by a reciprocal multiplication.
  function automatic logic [LEN_W-1:0] div3(input logic [LEN_W+1:0] x);
    logic [LEN_W+18:0] prod;
    prod = {17'd0, x} * {15'd0, 17'd43691};
    return prod[LEN_W+16:17];
  endfunction

endpackage

`default_nettype wire

[sv/lwfs_front.sv]
// Front part: accepts range samples and keeps the per-scan minimum, thirds sums
// and first sample; pushes one scan summary into the queue per scan. Uses lwfs_pkg.
`default_nettype none

module lwfs_front #(
  parameter int unsigned MAX_SCAN   = 4096,
  parameter int unsigned RANGE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [lwfs_pkg::RANGE_W-1:0]     in_range_mm,
  input  wire lwfs_pkg::lwfs_split_t            split,
  input  wire logic                             q_full,
  output logic                                  push,
  output lwfs_pkg::lwfs_scan_t                  push_data
);
  import lwfs_pkg::*;

  localparam int unsigned RW = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam int unsigned IW = $clog2(MAX_SCAN);
  localparam int unsigned CW = (IW + 1 > LEN_W) ? IW + 1 : LEN_W;
  localparam int unsigned SW = RW + IW;

  logic [IW-1:0]      idx_r, idx_nxt;
  logic [RANGE_W-1:0] min_r, min_nxt;
  logic [RANGE_W-1:0] first_r, first_nxt;
  logic [SW-1:0]      rsum_r, rsum_nxt;
  logic [SW-1:0]      lsum_r, lsum_nxt;

  logic               accept;
  logic [RANGE_W-1:0] r;
  logic [CW-1:0]      idx_ext;
  logic               in_right;
  logic               in_left;
  logic               last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    r        = RANGE_W'({{(RANGE_W-RW){1'b0}}, in_range_mm[RW-1:0]});
    idx_ext  = CW'(idx_r);
    in_right = idx_ext < CW'(split.third);
    in_left  = !in_right && (idx_ext >= CW'(split.two_third));
    last     = (idx_ext + CW'(1)) >= CW'(split.eff_len);

    first_nxt = (idx_r == '0) ? r : first_r;
    min_nxt   = (r < min_r) ? r : min_r;
    rsum_nxt  = in_right ? rsum_r + SW'(r[RW-1:0]) : rsum_r;
    lsum_nxt  = in_left ? lsum_r + SW'(r[RW-1:0]) : lsum_r;
    idx_nxt   = idx_r + IW'(1);

    push                  = accept && last;
    push_data.min_range   = min_nxt;
    push_data.left_closer = lsum_nxt < rsum_nxt;
    push_data.first_range = first_nxt;
    push_data.last_range  = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      min_r   <= MIN_START;
      first_r <= '0;
      rsum_r  <= '0;
      lsum_r  <= '0;
    end else if (accept) begin
      if (last) begin
        idx_r   <= '0;
        min_r   <= MIN_START;
        first_r <= '0;
        rsum_r  <= '0;
        lsum_r  <= '0;
      end else begin
        idx_r   <= idx_nxt;
        min_r   <= min_nxt;
        first_r <= first_nxt;
        rsum_r  <= rsum_nxt;
        lsum_r  <= lsum_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lwfs_queue.sv]
// Two-entry queue of scan summaries between the front and back parts.
// Uses lwfs_pkg for the summary type.
`default_nettype none

module lwfs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lwfs_pkg::lwfs_scan_t push_data,
  input  wire logic                 pop,
  output logic                      q_valid,
  output logic                      q_full,
  output lwfs_pkg::lwfs_scan_t      q_data
);
  import lwfs_pkg::*;

  lwfs_scan_t  mem_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign q_valid = cnt_r != 2'd0;
  assign q_full  = cnt_r == 2'd2;
  assign q_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/lwfs_back.sv]
// Back part: turns each scan summary into a speed and turn command, keeps the
// wall latch and holds the result register. Uses lwfs_pkg.
`default_nettype none

module lwfs_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire lwfs_pkg::lwfs_scan_t           q_data,
  output logic                                pop,
  input  wire lwfs_pkg::lwfs_thresh_t         thresh,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lwfs_pkg::SPEED_W-1:0]        out_linear_speed,
  output logic signed [lwfs_pkg::TURN_W-1:0]  out_angular_rate,
  output logic                                out_wall_found,
  output logic                                out_wall_left
);
  import lwfs_pkg::*;

  logic                      valid_r, valid_nxt;
  logic                      wall_r, wall_nxt;
  logic                      side_r, side_nxt;
  logic [SPEED_W-1:0]        speed_r, speed_nxt;
  logic signed [TURN_W-1:0]  turn_r, turn_nxt;

  assign pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    wall_nxt  = wall_r;
    side_nxt  = side_r;
    if (q_data.min_range < thresh.stop_dist) begin
      speed_nxt = SPEED_CRAWL;
      wall_nxt  = 1'b1;
    end else if (q_data.min_range < thresh.wall_dist) begin
      speed_nxt = SPEED_SLOW;
      if (!wall_r) begin
        wall_nxt = 1'b1;
        side_nxt = q_data.left_closer;
      end
    end else if (q_data.min_range < thresh.caution_dist) begin
      speed_nxt = SPEED_MEDIUM;
    end else begin
      speed_nxt = SPEED_FAST;
    end

    if (!wall_nxt) begin
      turn_nxt = TURN_NONE;
    end else if (side_nxt) begin
      turn_nxt = (q_data.last_range < thresh.follow_dist) ? TURN_RIGHT : TURN_LEFT;
    end else begin
      turn_nxt = (q_data.first_range < thresh.follow_dist) ? TURN_LEFT : TURN_RIGHT;
    end

    valid_nxt = pop || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wall_r  <= 1'b0;
      side_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        wall_r <= wall_nxt;
        side_r <= side_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      speed_r <= speed_nxt;
      turn_r  <= turn_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_linear_speed = speed_r;
  assign out_angular_rate = turn_r;
  assign out_wall_found   = wall_r;
  assign out_wall_left    = side_r;

endmodule

`default_nettype wire

[sv/lidar_wall_follow_speed.sv]
// Laser wall-follow speed selector: range samples stream in on the input channel,
// one command per scan leaves on the result channel. Top level; uses lwfs_pkg,
// lwfs_front, lwfs_queue and lwfs_back, and holds the configuration registers.
//
// Each input transaction carries one range sample in mm. After scan_length
// samples (at least 3, at most MAX_SCAN) the block emits one result transaction
// with the forward speed, the turn rate and the wall latch and side. Samples are
// taken one per cycle while in_ready is high. The per-sample work is one compare
// and two adds in the front part. Scan summaries pass through a two-entry queue
// to the back part, which holds the result register. When the receiver stalls,
// the back part holds its result, the queue fills, and in_ready drops only once
// two more summaries wait. Reset is synchronous: it restores the register
// defaults, clears the scan state and the wall latch, and empties the queue. The
// user must write the registers over the APB-style port only while no scan
// result is pending; the block itself does not enforce this.
`default_nettype none

module lidar_wall_follow_speed #(
  parameter int unsigned MAX_SCAN   = 4096,
  parameter int unsigned RANGE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [lwfs_pkg::RANGE_W-1:0]       in_range_mm,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [lwfs_pkg::SPEED_W-1:0]            out_linear_speed,
  output logic signed [lwfs_pkg::TURN_W-1:0]      out_angular_rate,
  output logic                                    out_wall_found,
  output logic                                    out_wall_left,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lwfs_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [lwfs_pkg::DATA_W-1:0]        pwdata,
  output logic [lwfs_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready
);
  import lwfs_pkg::*;

  localparam int unsigned MW = $clog2(MAX_SCAN + 1) + 1;

  function automatic lwfs_split_t make_split(input logic [LEN_W-1:0] v);
    lwfs_split_t s;
    logic [LEN_W-1:0] n;
    if (v < LEN_W'(3)) begin
      n = LEN_W'(3);
    end else if (((MW > LEN_W) ? MW : LEN_W)'(v) > ((MW > LEN_W) ? MW : LEN_W)'(MAX_SCAN)) begin
      n = LEN_W'(MAX_SCAN);
    end else begin
      n = v;
    end
    s.eff_len   = n;
    s.third     = div3({2'b00, n});
    s.two_third = div3({1'b0, n, 1'b0});
    return s;
  endfunction

  logic [LEN_W-1:0]   scan_len_r;
  lwfs_split_t        split_r;
  lwfs_thresh_t       thresh_r;
  logic               wr_en;
  lwfs_reg_t          reg_sel;

  logic               q_full;
  logic               q_valid;
  logic               push;
  logic               pop;
  lwfs_scan_t         push_data;
  lwfs_scan_t         q_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = lwfs_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_len_r            <= RST_SCAN_LENGTH;
      split_r               <= make_split(RST_SCAN_LENGTH);
      thresh_r.stop_dist    <= RST_STOP_DISTANCE;
      thresh_r.wall_dist    <= RST_WALL_DISTANCE;
      thresh_r.caution_dist <= RST_CAUTION_DISTANCE;
      thresh_r.follow_dist  <= RST_FOLLOW_DISTANCE;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SCAN_LENGTH: begin
          scan_len_r <= pwdata[LEN_W-1:0];
          split_r    <= make_split(pwdata[LEN_W-1:0]);
        end
        REG_STOP_DISTANCE:    thresh_r.stop_dist    <= pwdata[RANGE_W-1:0];
        REG_WALL_DISTANCE:    thresh_r.wall_dist    <= pwdata[RANGE_W-1:0];
        REG_CAUTION_DISTANCE: thresh_r.caution_dist <= pwdata[RANGE_W-1:0];
        REG_FOLLOW_DISTANCE:  thresh_r.follow_dist  <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCAN_LENGTH:      prdata = DATA_W'(scan_len_r);
      REG_STOP_DISTANCE:    prdata = DATA_W'(thresh_r.stop_dist);
      REG_WALL_DISTANCE:    prdata = DATA_W'(thresh_r.wall_dist);
      REG_CAUTION_DISTANCE: prdata = DATA_W'(thresh_r.caution_dist);
      REG_FOLLOW_DISTANCE:  prdata = DATA_W'(thresh_r.follow_dist);
      default:              prdata = '0;
    endcase
  end

  lwfs_front #(
    .MAX_SCAN   (MAX_SCAN),
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_range_mm (in_range_mm),
    .split       (split_r),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  lwfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  lwfs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .pop              (pop),
    .thresh           (thresh_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_wall_found   (out_wall_found),
    .out_wall_left    (out_wall_left)
  );

endmodule

`default_nettype wire
